>>> rtl/core/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// shared types, codes and the sequencer control store of the slot alarm
// scheduler
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int TIME_W = 15;
    localparam int SLOT_W = 6;
    localparam int BITS_W = 8;
    localparam int MODE_W = 2;

    // operation codes of a command word
    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2,
        OP_START = 2'd3
    } op_t;

    // command word
    typedef struct packed {
        logic [1:0]        operation;
        logic [SLOT_W-1:0] slot;
        logic [BITS_W-1:0] alarm_bits;
        logic [TIME_W-1:0] time_req;
    } cmd_t;

    // result word
    typedef struct packed {
        logic              timer_enable;
        logic              alarm_valid;
        logic [TIME_W-1:0] next_alarm_time;
        logic [SLOT_W-1:0] current_slot;
        logic              start_actions;
    } rsp_t;

    // datapath actions
    typedef enum logic [3:0] {
        DP_NOP,
        DP_READ,
        DP_WRITE,
        DP_EMIT_OFF,
        DP_START,
        DP_DIVIDE,
        DP_SCAN_INIT,
        DP_SCAN_STEP,
        DP_EMIT_TICK
    } dp_op_t;

    // jump conditions: when true the step goes to alt (to the entry step for C_DISPATCH), else to next
    typedef enum logic [2:0] {
        C_NEVER,
        C_DISPATCH,
        C_BAD_SLOT,
        C_SCAN_MISS
    } cond_t;

    // program steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_TICK_OFF,
        S_START,
        S_DIVIDE,
        S_SCAN_INIT,
        S_SCAN,
        S_EMIT
    } step_t;

    typedef struct packed {
        dp_op_t dp;
        cond_t  cond;
        step_t  next;
        step_t  alt;
    } uword_t;

    // sequencer to datapath
    typedef struct packed {
        logic   accept;
        dp_op_t dp;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic mode_on;
        logic bad_slot;
        logic scan_miss;
    } stat_t;

    // control store
    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            S_IDLE:      w = '{dp: DP_NOP,       cond: C_DISPATCH,  next: S_IDLE,      alt: S_IDLE};
            S_READ:      w = '{dp: DP_READ,      cond: C_BAD_SLOT,  next: S_WRITE,     alt: S_IDLE};
            S_WRITE:     w = '{dp: DP_WRITE,     cond: C_NEVER,     next: S_IDLE,      alt: S_IDLE};
            S_TICK_OFF:  w = '{dp: DP_EMIT_OFF,  cond: C_NEVER,     next: S_IDLE,      alt: S_IDLE};
            S_START:     w = '{dp: DP_START,     cond: C_NEVER,     next: S_IDLE,      alt: S_IDLE};
            S_DIVIDE:    w = '{dp: DP_DIVIDE,    cond: C_NEVER,     next: S_SCAN_INIT, alt: S_IDLE};
            S_SCAN_INIT: w = '{dp: DP_SCAN_INIT, cond: C_NEVER,     next: S_SCAN,      alt: S_IDLE};
            S_SCAN:      w = '{dp: DP_SCAN_STEP, cond: C_SCAN_MISS, next: S_EMIT,      alt: S_SCAN};
            S_EMIT:      w = '{dp: DP_EMIT_TICK, cond: C_NEVER,     next: S_IDLE,      alt: S_IDLE};
            default:     w = '{dp: DP_NOP,       cond: C_NEVER,     next: S_IDLE,      alt: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/sas_ram.sv
// ----------------------------------------------------------------------------
// sas_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sas_sequencer.sv
// ----------------------------------------------------------------------------
// sas_sequencer
// step counter with control store lookup, dispatch and conditional jumps
// ----------------------------------------------------------------------------
module sas_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        operation,
    input  sas_pkg::stat_t    stat,
    output sas_pkg::ctrl_t    ctrl,
    output logic              busy
);

    sas_pkg::step_t  pc_reg;
    sas_pkg::step_t  pc_next;
    sas_pkg::uword_t uw;
    sas_pkg::step_t  entry;
    logic            accept;
    logic            take_alt;

    // entry step for an accepted command word
    always_comb
    begin
        unique case (operation) inside
            sas_pkg::OP_SET,
            sas_pkg::OP_CLEAR: entry = sas_pkg::S_READ;
            sas_pkg::OP_TICK:  entry = stat.mode_on ? sas_pkg::S_DIVIDE : sas_pkg::S_TICK_OFF;
            sas_pkg::OP_START: entry = stat.mode_on ? sas_pkg::S_START : sas_pkg::S_IDLE;
            default:           entry = sas_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= sas_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        uw     = sas_pkg::ucode(pc_reg);
        accept = start && (pc_reg == sas_pkg::S_IDLE);
        unique case (uw.cond)
            sas_pkg::C_NEVER:     take_alt = 1'b0;
            sas_pkg::C_DISPATCH:  take_alt = accept;
            sas_pkg::C_BAD_SLOT:  take_alt = stat.bad_slot;
            sas_pkg::C_SCAN_MISS: take_alt = stat.scan_miss;
            default:              take_alt = 1'b0;
        endcase
        if (uw.cond == sas_pkg::C_DISPATCH)
        begin
            pc_next = take_alt ? entry : uw.next;
        end
        else
        begin
            pc_next = take_alt ? uw.alt : uw.next;
        end
        ctrl.accept = accept;
        ctrl.dp     = uw.dp;
    end

    assign busy = (pc_reg != sas_pkg::S_IDLE);

endmodule

>>> rtl/core/sas_datapath.sv
// ----------------------------------------------------------------------------
// sas_datapath
// mode register, alarm table with nonzero flags, reciprocal divider, slot
// scan and result register
// ----------------------------------------------------------------------------
module sas_datapath #(
    parameter int SLOT_COUNT  = 50,
    parameter int SLOT_TICKS  = 654,
    parameter int ALARM_WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sas_pkg::ctrl_t             ctrl,
    input  sas_pkg::cmd_t              cmd,
    input  logic                       cfg_we,
    input  logic [sas_pkg::MODE_W-1:0] cfg_wdata,
    output sas_pkg::stat_t             stat,
    output logic                       result_valid,
    output sas_pkg::rsp_t              rsp
);

    localparam int TW     = sas_pkg::TIME_W;
    localparam int SW     = $clog2(SLOT_COUNT);
    localparam int SW1    = SW + 1;
    // reciprocal of SLOT_TICKS, exact for every time below 2**TW
    localparam int REC_SH = TW + $clog2(SLOT_TICKS);
    localparam int REC_MW = TW + 2;
    localparam int PROD_W = TW + REC_MW;
    localparam logic [REC_MW-1:0] REC_M =
        REC_MW'(((64'd1 << REC_SH) + 64'(SLOT_TICKS) - 64'd1) / 64'(SLOT_TICKS));

    logic [sas_pkg::MODE_W-1:0] mode_reg;
    logic [SLOT_COUNT-1:0]      nz_reg;
    logic [SLOT_COUNT-1:0]      nz_next;
    logic                       result_valid_reg;
    sas_pkg::rsp_t              rsp_reg;

    logic [1:0]             op_reg;
    logic [sas_pkg::SLOT_W-1:0] slot_reg;
    logic [ALARM_WIDTH-1:0] bits_reg;
    logic [TW-1:0]          quo_reg;
    logic [SW-1:0]          scan_reg;

    logic [SW-1:0]          slot_idx;
    logic [ALARM_WIDTH-1:0] rdata;
    logic [ALARM_WIDTH-1:0] old_bits;
    logic [ALARM_WIDTH-1:0] new_bits;
    logic [PROD_W-1:0]      rec_prod;
    logic [TW-1:0]          quo_calc;
    logic [SW-1:0]          scan_first;
    logic [SW-1:0]          scan_succ;
    logic [TW-1:0]          prod;
    logic                   ram_we;

    assign slot_idx = slot_reg[SW-1:0];

    // read-modify-write of one entry; an entry with a clear flag reads as zero
    assign old_bits = nz_reg[slot_idx] ? rdata : '0;
    assign new_bits = (op_reg == sas_pkg::OP_SET) ? (old_bits | bits_reg)
                                                  : (old_bits & ~bits_reg);
    assign ram_we   = (ctrl.dp == sas_pkg::DP_WRITE);

    // tick time over SLOT_TICKS by one constant multiply and a shift
    assign rec_prod = PROD_W'(quo_reg) * PROD_W'(REC_M);
    assign quo_calc = TW'(rec_prod >> REC_SH);

    // first slot after the tick slot, wrapping to slot 0
    assign scan_first = (quo_reg >= TW'(SLOT_COUNT - 1)) ? '0 : (quo_reg[SW-1:0] + SW'(1));
    assign scan_succ  = (({1'b0, scan_reg} + SW1'(1)) >= SW1'(SLOT_COUNT)) ? '0
                                                                          : (scan_reg + SW'(1));

    assign prod = TW'(scan_reg) * TW'(SLOT_TICKS);

    assign stat.mode_on   = (mode_reg != '0);
    assign stat.bad_slot  = ({1'b0, slot_reg} >= (sas_pkg::SLOT_W + 1)'(SLOT_COUNT));
    assign stat.scan_miss = (scan_reg != '0) && !nz_reg[scan_reg];

    sas_ram #(
        .WIDTH (ALARM_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (new_bits),
        .re    (ctrl.dp == sas_pkg::DP_READ),
        .raddr (slot_idx),
        .rdata (rdata)
    );

    always_comb
    begin
        nz_next = nz_reg;
        if (ctrl.dp == sas_pkg::DP_START)
        begin
            nz_next = '0;
        end
        else if (ram_we)
        begin
            nz_next[slot_idx] = (new_bits != '0);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= '0;
            nz_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            nz_reg           <= nz_next;
            result_valid_reg <= (ctrl.dp == sas_pkg::DP_EMIT_OFF) ||
                                (ctrl.dp == sas_pkg::DP_START)    ||
                                (ctrl.dp == sas_pkg::DP_EMIT_TICK);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            op_reg   <= cmd.operation;
            slot_reg <= cmd.slot;
            bits_reg <= ALARM_WIDTH'(cmd.alarm_bits);
            quo_reg  <= cmd.time_req;
        end
        unique case (ctrl.dp)
            sas_pkg::DP_DIVIDE:
            begin
                quo_reg <= quo_calc;
            end
            sas_pkg::DP_SCAN_INIT:
            begin
                scan_reg <= scan_first;
            end
            sas_pkg::DP_SCAN_STEP:
            begin
                if (stat.scan_miss)
                begin
                    scan_reg <= scan_succ;
                end
            end
            sas_pkg::DP_EMIT_OFF:
            begin
                rsp_reg <= '0;
            end
            sas_pkg::DP_START:
            begin
                rsp_reg.timer_enable    <= 1'b1;
                rsp_reg.alarm_valid     <= 1'b1;
                rsp_reg.next_alarm_time <= '0;
                rsp_reg.current_slot    <= '0;
                rsp_reg.start_actions   <= 1'b0;
            end
            sas_pkg::DP_EMIT_TICK:
            begin
                rsp_reg.timer_enable    <= 1'b1;
                rsp_reg.alarm_valid     <= 1'b1;
                rsp_reg.next_alarm_time <= prod;
                rsp_reg.current_slot    <= quo_reg[sas_pkg::SLOT_W-1:0];
                rsp_reg.start_actions   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign rsp          = rsp_reg;

endmodule

>>> rtl/core/slot_alarm_scheduler_top.sv
// ----------------------------------------------------------------------------
// slot_alarm_scheduler_top
// per-slot alarm table with next active slot search on each timer tick
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Set and clear
// words go through a read step and a write step (the read step only for an
// out-of-range slot) and give no result. A tick word in mode 0 and a start
// word go through a step (S_TICK_OFF or S_START) that loads the result
// register; a start word in mode 0 is dropped. A tick word with the timer on
// looks at 1 to SLOT_COUNT slots: a divide step divides the tick time by
// SLOT_TICKS with a constant reciprocal multiply, a set-up step sets up the
// scan, the scan then tests one slot flag per cycle and a last step forms
// the result. The result word is shown for exactly one cycle with
// result_valid high and cannot be held off, so the receiver must take it
// then. The mode register may be written only while busy is low.
// ----------------------------------------------------------------------------
module slot_alarm_scheduler_top #(
    parameter int SLOT_COUNT  = 50,
    parameter int SLOT_TICKS  = 654,
    parameter int ALARM_WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command word
    input  logic                       start,
    input  sas_pkg::cmd_t              cmd,
    output logic                       busy,
    // mode register
    input  logic                       cfg_we,
    input  logic [sas_pkg::MODE_W-1:0] cfg_wdata,
    // result word
    output logic                       result_valid,
    output sas_pkg::rsp_t              rsp
);

    sas_pkg::ctrl_t ctrl;
    sas_pkg::stat_t stat;

    // step counter and control store
    sas_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .stat      (stat),
        .ctrl      (ctrl),
        .busy      (busy)
    );

    // registers, divider, slot scan and alarm table
    sas_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .SLOT_TICKS  (SLOT_TICKS),
        .ALARM_WIDTH (ALARM_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .stat         (stat),
        .result_valid (result_valid),
        .rsp          (rsp)
    );

    // a result word always comes out as the program returns to idle
    a_result_idle : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result word while sequencer busy");

    // never two result words in consecutive cycles
    a_result_single : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back to back result words");

    // actions start only with the timer running and a new alarm
    a_actions_on : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rsp.start_actions) |-> (rsp.timer_enable && rsp.alarm_valid))
        else $error("actions started with timer off");

    // timer off word carries no alarm
    a_off_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !rsp.timer_enable) |->
            (!rsp.alarm_valid && (rsp.next_alarm_time == '0) && (rsp.current_slot == '0)))
        else $error("timer off word carries an alarm");

    // a tick word with the timer on never completes in the accept cycle
    a_busy_after_tick : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.operation == sas_pkg::OP_TICK) && stat.mode_on) |=> busy)
        else $error("tick word not processed");

endmodule
